// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds through reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/md5he_pkg.sv =====
// Types, round constants and initial values for the MD5 engine.
`timescale 1ns / 1ps

package md5he_pkg;

    typedef logic [3:0][31:0] md5he_words_t;

    // One write into the block buffer; lanes are byte enables.
    typedef struct packed {
        logic        we;
        logic [3:0]  addr;
        logic [3:0]  lane_en;
        logic [31:0] data;
    } md5he_buf_wr_t;

    // Status from the round unit to the sequencer.
    typedef struct packed {
        logic       last_round;
        logic [3:0] msg_idx;
    } md5he_rnd_stat_t;

    localparam md5he_words_t MD5_IV = {
        32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [31:0] MD5_PAD_BYTE = 32'h0000_0080;
    localparam logic [3:0]  MD5_LEN_WORD = 4'd14;
    localparam logic [3:0]  MD5_LAST_WORD = 4'd15;
    localparam logic [2:0]  MD5_WORD_BYTES = 3'd4;

    localparam logic [31:0] MD5_K [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_S [0:15] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

endpackage

// ===== rtl/core/md5he_buf.sv =====
// Sixteen-word block buffer with byte-lane writes and one read port.
`timescale 1ns / 1ps

module md5he_buf
    import md5he_pkg::*;
(
    input  logic          aclk,
    input  md5he_buf_wr_t wr,
    input  logic [3:0]    rd_idx,
    output logic [31:0]   rd_data
);

    logic [31:0] words_reg [0:15];

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            for (int l = 0; l < 4; l++) begin
                if (wr.lane_en[l]) begin
                    words_reg[wr.addr][8*l +: 8] <= wr.data[8*l +: 8];
                end
            end
        end
    end

    assign rd_data = words_reg[rd_idx];

endmodule

// ===== rtl/core/md5he_round.sv =====
// MD5 round unit: one of the 64 rounds per cycle while advance is high, on the working registers.
`timescale 1ns / 1ps

module md5he_round
    import md5he_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic            advance,
    input  md5he_words_t    chain_in,
    input  logic [31:0]     msg_word,
    output md5he_rnd_stat_t stat,
    output md5he_words_t    work_words
);

    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  rnd_reg;
    logic [31:0] f_val;
    logic [3:0]  g_idx;
    logic [3:0]  i4;
    logic [31:0] t_sum;
    logic [4:0]  s_amt;
    logic [63:0] rot_wide;

    assign i4 = rnd_reg[3:0];

    always_comb begin
        case (rnd_reg[5:4])
            2'd0: begin
                f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
                g_idx = i4;
            end
            2'd1: begin
                f_val = c_reg ^ (d_reg & (b_reg ^ c_reg));
                g_idx = 4'({i4, 2'b00} + {2'b00, i4} + 6'd1);
            end
            2'd2: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = 4'({i4, 1'b0} + {1'b0, i4} + 5'd5);
            end
            default: begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = 4'({i4, 3'b000} - {3'b000, i4});
            end
        endcase
    end

    assign t_sum    = a_reg + f_val + MD5_K[rnd_reg] + msg_word;
    assign s_amt    = MD5_S[{rnd_reg[5:4], rnd_reg[1:0]}];
    assign rot_wide = {t_sum, t_sum} << s_amt;

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= chain_in[0];
            b_reg <= chain_in[1];
            c_reg <= chain_in[2];
            d_reg <= chain_in[3];
        end else if (advance) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot_wide[63:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_reg <= '0;
        end else if (start) begin
            rnd_reg <= '0;
        end else if (advance) begin
            rnd_reg <= rnd_reg + 6'd1;
        end
    end

    assign stat.last_round = (rnd_reg == 6'd63);
    assign stat.msg_idx    = g_idx;
    assign work_words      = {d_reg, c_reg, b_reg, a_reg};

endmodule

// ===== rtl/core/md5_hash_engine_top.sv =====
// MD5 engine top level: word intake, padding sequencer and chaining state.
//
// Input channel s_*: one beat carries a little-endian word (s_data_word,
// first byte in bits 7:0), its valid byte count s_byte_count (0..4, values
// above 4 count as 4) and s_last_word. s_ready is high only while the engine
// is idle, so at most one beat is in work at a time.
// A beat is accepted, then written into the buffer, with a second write if its
// bytes straddle a buffer word. When a 64-byte block fills, the shared round
// unit runs 64 rounds, one per cycle, then folds the result into the chaining
// words and resumes the beat.
// A last beat also walks the padding one buffer word per cycle up to byte 56,
// pausing for a compression if the padding spills, writes the 64-bit length as
// two words and runs one or two compressions.
// Output channel m_*: one beat per message, digest bytes 0..7 on
// m_digest_first_half and 8..15 on m_digest_second_half. The digest sits in
// an output register; a stalled receiver holds the engine only when the next
// digest is ready while the previous one has not been taken.
// Reset (aresetn low, synchronous) restores the initial chaining words, clears
// the byte position and bit count and drops m_valid.
`timescale 1ns / 1ps

module md5_hash_engine_top
    import md5he_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_first_half,
    output logic [63:0] m_digest_second_half
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_PAD  = 3'd2;
    localparam logic [2:0] ST_ZERO = 3'd3;
    localparam logic [2:0] ST_LEN  = 3'd4;
    localparam logic [2:0] ST_COMP = 3'd5;
    localparam logic [2:0] ST_ADD  = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    logic [2:0]   state_reg, state_next;
    logic [2:0]   ret_reg, ret_next;
    logic [5:0]   pos_reg, pos_next;
    logic [63:0]  bits_reg, bits_next;
    logic [31:0]  data_reg, data_next;
    logic [2:0]   rem_reg, rem_next;
    logic         last_reg, last_next;
    md5he_words_t chain_reg, chain_next;
    logic         m_valid_reg, m_valid_next;
    logic [63:0]  dig1_reg, dig1_next;
    logic [63:0]  dig2_reg, dig2_next;

    md5he_buf_wr_t   buf_wr;
    md5he_rnd_stat_t rnd_stat;
    md5he_words_t    work_words;
    logic [31:0]     msg_word;
    logic            rnd_start;
    logic            rnd_adv;

    logic [2:0] room;
    logic [2:0] take;
    logic [6:0] pos_sum;
    logic [3:0] lane_mask;
    logic [3:0] word_inc;

    md5he_buf u_buf (
        .aclk    (aclk),
        .wr      (buf_wr),
        .rd_idx  (rnd_stat.msg_idx),
        .rd_data (msg_word)
    );

    md5he_round u_round (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (rnd_start),
        .advance    (rnd_adv),
        .chain_in   (chain_reg),
        .msg_word   (msg_word),
        .stat       (rnd_stat),
        .work_words (work_words)
    );

    // Bytes that fit before the next word boundary.
    assign room      = MD5_WORD_BYTES - {1'b0, pos_reg[1:0]};
    assign take      = (rem_reg < room) ? rem_reg : room;
    assign pos_sum   = {1'b0, pos_reg} + {4'b0000, take};
    assign lane_mask = 4'((4'b1111 >> (MD5_WORD_BYTES - take)) << pos_reg[1:0]);
    assign word_inc  = pos_reg[5:2] + 4'd1;

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        pos_next     = pos_reg;
        bits_next    = bits_reg;
        data_next    = data_reg;
        rem_next     = rem_reg;
        last_next    = last_reg;
        chain_next   = chain_reg;
        m_valid_next = m_valid_reg;
        dig1_next    = dig1_reg;
        dig2_next    = dig2_reg;
        buf_wr       = '0;
        rnd_start    = 1'b0;
        rnd_adv      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    data_next  = s_data_word;
                    rem_next   = (s_byte_count > MD5_WORD_BYTES) ? MD5_WORD_BYTES
                                                                 : s_byte_count;
                    last_next  = s_last_word;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (rem_reg != 3'd0) begin
                    buf_wr.we      = 1'b1;
                    buf_wr.addr    = pos_reg[5:2];
                    buf_wr.lane_en = lane_mask;
                    buf_wr.data    = data_reg << {pos_reg[1:0], 3'b000};
                    data_next      = data_reg >> {take, 3'b000};
                    rem_next       = rem_reg - take;
                    pos_next       = pos_sum[5:0];
                    bits_next      = bits_reg + {58'd0, take, 3'b000};
                    if (pos_sum[6]) begin
                        rnd_start  = 1'b1;
                        ret_next   = ST_LOAD;
                        state_next = ST_COMP;
                    end else if (rem_reg == take) begin
                        state_next = last_reg ? ST_PAD : ST_IDLE;
                    end
                end else begin
                    state_next = last_reg ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                // Mark byte, then zero to the end of the word.
                buf_wr.we      = 1'b1;
                buf_wr.addr    = pos_reg[5:2];
                buf_wr.lane_en = 4'(4'b1111 << pos_reg[1:0]);
                buf_wr.data    = MD5_PAD_BYTE << {pos_reg[1:0], 3'b000};
                pos_next       = {word_inc, 2'b00};
                state_next     = ST_ZERO;
                if (pos_reg[5:2] == MD5_LAST_WORD) begin
                    rnd_start  = 1'b1;
                    ret_next   = ST_ZERO;
                    state_next = ST_COMP;
                end
            end
            ST_ZERO: begin
                buf_wr.we      = 1'b1;
                buf_wr.addr    = pos_reg[5:2];
                buf_wr.lane_en = 4'b1111;
                pos_next       = {word_inc, 2'b00};
                if (pos_reg[5:2] == MD5_LEN_WORD) begin
                    buf_wr.data = bits_reg[31:0];
                    state_next  = ST_LEN;
                end else begin
                    buf_wr.data = '0;
                    if (pos_reg[5:2] == MD5_LAST_WORD) begin
                        rnd_start  = 1'b1;
                        ret_next   = ST_ZERO;
                        state_next = ST_COMP;
                    end
                end
            end
            ST_LEN: begin
                buf_wr.we      = 1'b1;
                buf_wr.addr    = MD5_LAST_WORD;
                buf_wr.lane_en = 4'b1111;
                buf_wr.data    = bits_reg[63:32];
                pos_next       = '0;
                rnd_start      = 1'b1;
                ret_next       = ST_FIN;
                state_next     = ST_COMP;
            end
            ST_COMP: begin
                rnd_adv = 1'b1;
                if (rnd_stat.last_round) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int j = 0; j < 4; j++) begin
                    chain_next[j] = chain_reg[j] + work_words[j];
                end
                state_next = ret_reg;
            end
            ST_FIN: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    dig1_next    = {chain_reg[1], chain_reg[0]};
                    dig2_next    = {chain_reg[3], chain_reg[2]};
                    m_valid_next = 1'b1;
                    chain_next   = MD5_IV;
                    bits_next    = '0;
                    pos_next     = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            pos_reg     <= '0;
            bits_reg    <= '0;
            rem_reg     <= '0;
            last_reg    <= 1'b0;
            chain_reg   <= MD5_IV;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            pos_reg     <= pos_next;
            bits_reg    <= bits_next;
            rem_reg     <= rem_next;
            last_reg    <= last_next;
            chain_reg   <= chain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        dig1_reg <= dig1_next;
        dig2_reg <= dig2_next;
    end

    assign s_ready              = (state_reg == ST_IDLE);
    assign m_valid              = m_valid_reg;
    assign m_digest_first_half  = dig1_reg;
    assign m_digest_second_half = dig2_reg;

endmodule

// ===== rtl/core/md5he_checker.sv =====
// Port-level checks on the MD5 engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module md5he_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_word,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_digest_first_half,
    input logic [63:0] m_digest_second_half
);

    `ASSERT_CLK_ALWAYS(a_reset_drops_valid, aclk, !aresetn |=> !m_valid, "m_valid high after reset")

    `ASSERT_CLK(a_busy_after_beat, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "input taken while a beat is in work")

    `ASSERT_CLK(a_no_digest_mid_msg, aclk, aresetn, (s_valid && s_ready && !s_last_word) |=> !$rose(m_valid), "digest raised right after a non-last beat")

    `ASSERT_CLK(a_digest_holds, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_digest_first_half) && $stable(m_digest_second_half)), "stalled digest beat changed")

endmodule

bind md5_hash_engine_top md5he_checker u_md5he_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .s_last_word          (s_last_word),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_digest_first_half  (m_digest_first_half),
    .m_digest_second_half (m_digest_second_half)
);

// ===== tb/md5_hash_engine_checker.sv =====
// Channel monitor for the MD5 engine: predicts each digest and compares it.
`timescale 1ns / 1ps

module md5_hash_engine_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_digest_first_half,
    input  logic [63:0] m_digest_second_half,
    output int          mismatch_count,
    output int          digests_pending
);

    localparam int BLOCK_BYTES = 64;
    localparam int LENGTH_OFFSET = 56;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int REPORT_LIMIT = 10;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_S [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct packed {
        logic [63:0] first_half;
        logic [63:0] second_half;
    } digest_t;

    logic [31:0] chain [4];
    logic [31:0] msg_block [16];
    int          block_pos;
    logic [63:0] msg_bits;
    digest_t     digest_queue [$];
    int          failures;

    function automatic logic [31:0] rotl32(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_chain();
        chain[0] = 32'h67452301;
        chain[1] = 32'hefcdab89;
        chain[2] = 32'h98badcfe;
        chain[3] = 32'h10325476;
        block_pos = 0;
        msg_bits = '0;
    endfunction

    function automatic void md5_compress();
        logic [31:0] a, b, c, d, f, t;
        int g;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin
                    f = d ^ (b & (c ^ d));
                    g = i;
                end
                1: begin
                    f = c ^ (d & (b ^ c));
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            t = a + f + ROUND_K[i] + msg_block[g];
            a = d;
            d = c;
            c = b;
            b = b + rotl32(t, ROT_S[(i / 16) * 4 + i % 4]);
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endfunction

    // Lane 0 clears the rest of the word, so stale bytes never survive.
    function automatic void absorb_byte(logic [7:0] value);
        int w;
        int lane;
        w = block_pos / 4;
        lane = block_pos % 4;
        if (lane == 0) begin
            msg_block[w] = {24'h0, value};
        end else begin
            msg_block[w][lane * 8 +: 8] = value;
        end
        block_pos++;
        if (block_pos == BLOCK_BYTES) begin
            md5_compress();
            block_pos = 0;
        end
    endfunction

    function automatic void absorb_beat(logic [31:0] word, logic [2:0] count, logic last);
        int n;
        logic [63:0] length_bits;
        digest_t dg;
        n = (count > 3'd4) ? 4 : int'(count);
        for (int k = 0; k < n; k++) begin
            absorb_byte(word[k * 8 +: 8]);
            msg_bits += 64'd8;
        end
        if (last) begin
            length_bits = msg_bits;
            absorb_byte(PAD_MARK);
            if (block_pos > LENGTH_OFFSET) begin
                while (block_pos != 0) absorb_byte(8'h00);
            end
            while (block_pos < LENGTH_OFFSET) absorb_byte(8'h00);
            for (int k = 0; k < 8; k++) absorb_byte(length_bits[k * 8 +: 8]);
            dg.first_half = {chain[1], chain[0]};
            dg.second_half = {chain[3], chain[2]};
            digest_queue.push_back(dg);
            restart_chain();
        end
    endfunction

    function automatic void flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $display("[%0t] %s mismatch: expected %h, got %h", $realtime, field, want, got);
        end
    endfunction

    initial begin
        failures = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_chain();
            digest_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (digest_queue.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $display("[%0t] digest beat with none outstanding: %h %h",
                                 $realtime, m_digest_first_half, m_digest_second_half);
                    end
                end else begin
                    digest_t want;
                    want = digest_queue.pop_front();
                    if (m_digest_first_half !== want.first_half) begin
                        flag_mismatch("digest_first_half", want.first_half,
                                      m_digest_first_half);
                    end
                    if (m_digest_second_half !== want.second_half) begin
                        flag_mismatch("digest_second_half", want.second_half,
                                      m_digest_second_half);
                    end
                end
            end
            if (s_valid && s_ready) begin
                absorb_beat(s_data_word, s_byte_count, s_last_word);
            end
        end
        mismatch_count <= failures;
        digests_pending <= digest_queue.size();
    end

endmodule

// ===== tb/md5_hash_engine_top_tb.sv =====
// Stimulus, reset and verdict for the MD5 engine testbench.
`timescale 1ns / 1ps

module md5_hash_engine_top_tb;

    localparam int ITEM_TARGET = 800;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word = '0;
    logic [2:0]  s_byte_count = '0;
    logic        s_last_word = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_digest_first_half;
    logic [63:0] m_digest_second_half;

    int mismatch_count;
    int digests_pending;
    int idle_cycles = 0;
    int words_sent = 0;
    bit no_idle = 1'b0;

    always #2 aclk = ~aclk;

    md5_hash_engine_top dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_data_word          (s_data_word),
        .s_byte_count         (s_byte_count),
        .s_last_word          (s_last_word),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_digest_first_half  (m_digest_first_half),
        .m_digest_second_half (m_digest_second_half)
    );

    md5_hash_engine_checker digest_check (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_data_word          (s_data_word),
        .s_byte_count         (s_byte_count),
        .s_last_word          (s_last_word),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_digest_first_half  (m_digest_first_half),
        .m_digest_second_half (m_digest_second_half),
        .mismatch_count       (mismatch_count),
        .digests_pending      (digests_pending)
    );

    // Hold valid and payload until the beat is taken.
    task automatic send_beat(input logic [31:0] word, input logic [2:0] count,
                             input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_word <= word;
        s_byte_count <= count;
        s_last_word <= last;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // Drop valid so the last beat is not taken again, and let the monitor's
    // registered pending count catch up before polling it.
    task automatic await_digests();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (digests_pending != 0) @(posedge aclk);
    endtask

    // Mostly full words with a ragged tail; now and then a short word mid-message.
    task automatic send_random_message();
        int n_words;
        logic [2:0] count;
        n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 40) : $urandom_range(0, 18);
        for (int k = 0; k < n_words; k++) begin
            count = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_beat($urandom, count, 1'b0);
        end
        send_beat($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_beat(32'h0000_0000, 3'd0, 1'b1);          // empty message
        send_beat(32'h0063_6261, 3'd3, 1'b1);          // "abc"
        send_beat(32'hffff_ffff, 3'd7, 1'b1);          // oversized count on the last word
        // short words before the last leave the byte position unaligned
        send_beat(32'hffff_ffff, 3'd1, 1'b0);
        send_beat(32'h0000_a55a, 3'd2, 1'b0);
        send_beat(32'hdead_beef, 3'd0, 1'b0);
        send_beat(32'h0000_0000, 3'd4, 1'b1);
        send_beat(32'hffff_ffff, 3'd5, 1'b0);
        send_beat(32'h1234_5678, 3'd6, 1'b0);
        send_beat(32'h8000_0001, 3'd2, 1'b1);
        // 56 bytes: the length no longer fits, so padding spills into an extra block
        for (int k = 0; k < 13; k++) begin
            send_beat({4{8'(k * 19)}}, 3'd4, 1'b0);
        end
        send_beat(32'hffff_ffff, 3'd4, 1'b1);
        await_digests();

        while (words_sent < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 11) == 0) begin
                await_digests();
            end
            send_random_message();
        end
        no_idle = 1'b0;
        await_digests();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && digests_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Count cycles with no beat on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
